// ===== hw/rtl/snt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package snt_pkg;

   // Field widths of the request and response items
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int TOTAL_W  = 7;

   // Request actions (code 3 is served as a find)
   localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

   // Which result the datapath captures
   typedef enum logic [2:0] {
      RES_NOT_FOUND,
      RES_FULL,
      RES_FLOOR,
      RES_HIT,
      RES_PLACED
   } res_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         load_req;
      logic         rd_mid;
      logic         step_search;
      logic         rd_floor;
      logic         res_we;
      res_kind_type res_kind;
      logic         upd_value;
      logic         shift_start;
      logic         shift_step;
      logic         place;
      logic         inc_count;
      logic         dec_count;
      logic         load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic                span_open;
      logic                lo_zero;
      logic                key_eq;
      logic                table_full;
      logic                shift_none;
      logic                shift_done;
      logic [ACTION_W-1:0] action;
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/snt_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one table operation per item
interface snt_req_if;
   import snt_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [KEY_W-1:0]    search_key;
   logic [VALUE_W-1:0]  entry_value;

   modport source (output valid, action, search_key, entry_value, input ready);
   modport sink   (input valid, action, search_key, entry_value, output ready);
endinterface

// Response channel: one result item per request
interface snt_rsp_if;
   import snt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic                exact_match;
   logic [KEY_W-1:0]    found_key;
   logic [VALUE_W-1:0]  found_value;
   logic [TOTAL_W-1:0]  entry_total;

   modport source (output valid, status, position, exact_match, found_key, found_value,
                   entry_total, input ready);
   modport sink   (input valid, status, position, exact_match, found_key, found_value,
                   entry_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sorted_node_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table of one tree node, up to CAPACITY pairs in ascending unsigned key
// order, with find-floor, insert/update and remove-floor requests. One request is worked
// at a time. The floor search is a binary search over the key memory, each probe a read
// then a compare, for at most floor(log2(n))+1 probes with n entries held. Insert of a new
// key and remove then shift the entries from the insert slot, or past the removed one,
// one place over through the memory read and write ports. A new request is taken while
// the previous result still waits in the output register. Keys and values above KEY_BITS
// and VALUE_BITS are dropped on entry; the stores need no clearing after reset since only
// entries below the count are read.
module sorted_node_table_unit #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   snt_req_if.sink   req_ch,
   snt_rsp_if.source rsp_ch
);
   import snt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   snt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   snt_datapath #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_ch.action),
      .req_search_key  (req_ch.search_key),
      .req_entry_value (req_ch.entry_value),
      .rsp_status      (rsp_ch.status),
      .rsp_position    (rsp_ch.position),
      .rsp_exact_match (rsp_ch.exact_match),
      .rsp_found_key   (rsp_ch.found_key),
      .rsp_found_value (rsp_ch.found_value),
      .rsp_entry_total (rsp_ch.entry_total)
   );

`ifndef SYNTH
   // result never overwrites one that is still waiting
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("output register loaded while a result item is pending");

   // a full table never grows
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      stat.table_full |-> !cmd.inc_count)
      else $error("entry count incremented on a full table");

   // one request in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while another is in progress");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/snt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module snt_datapath #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire snt_pkg::cmd_type              cmd,
   output snt_pkg::stat_type                  stat,
   input  wire logic [snt_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [snt_pkg::KEY_W-1:0]     req_search_key,
   input  wire logic [snt_pkg::VALUE_W-1:0]   req_entry_value,
   output logic      [snt_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [snt_pkg::POS_W-1:0]     rsp_position,
   output logic                               rsp_exact_match,
   output logic      [snt_pkg::KEY_W-1:0]     rsp_found_key,
   output logic      [snt_pkg::VALUE_W-1:0]   rsp_found_value,
   output logic      [snt_pkg::TOTAL_W-1:0]   rsp_entry_total
);
   import snt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // Key and value stores
   logic [KEY_BITS-1:0]   key_mem [CAPACITY];
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];

   // Latched request
   logic [ACTION_W-1:0]   act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // Entry count and search window [lo, hi)
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid_full;
   logic [CW-1:0] lo_dec;
   logic [CW-1:0] count_dec;
   logic [AW-1:0] floor_addr;
   logic [AW-1:0] lo_addr;

   // Read port
   logic [AW-1:0]         rd_addr;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;

   // Shift engine
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          pend_ff, pend_in;
   logic          up_ff, up_in;

   // Write port
   logic                  key_we;
   logic                  val_we;
   logic [AW-1:0]         wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;

   // Result and output registers
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [AW-1:0]         res_pos_ff, res_pos_in;
   logic                  res_exact_ff, res_exact_in;
   logic [KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0] res_val_ff, res_val_in;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [POS_W-1:0]      out_pos_ff;
   logic                  out_exact_ff;
   logic [KEY_W-1:0]      out_key_ff;
   logic [VALUE_W-1:0]    out_val_ff;
   logic [TOTAL_W-1:0]    out_total_ff;

   logic key_eq;

   // Address arithmetic
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_full   = mid_sum[CW:1];
   assign lo_dec     = lo_ff - 1'b1;
   assign count_dec  = count_ff - 1'b1;
   assign floor_addr = lo_dec[AW-1:0];
   assign lo_addr    = lo_ff[AW-1:0];
   assign key_eq     = (rd_key_ff == key_ff);

   // Status to the controller
   always_comb begin
      stat.span_open  = (lo_ff < hi_ff);
      stat.lo_zero    = (lo_ff == '0);
      stat.key_eq     = key_eq;
      stat.table_full = (count_ff >= CAP_COUNT);
      stat.shift_none = (count_ff == lo_ff);
      stat.shift_done = (rem_ff == '0);
      stat.action     = act_ff;
   end

   // Read address select
   always_comb begin
      if (cmd.shift_step) begin
         rd_addr = ptr_ff;
      end else if (cmd.rd_floor) begin
         rd_addr = floor_addr;
      end else begin
         rd_addr = mid_full[AW-1:0];
      end
   end

   // Write port select: shift move, new pair, or value update
   always_comb begin
      key_we  = 1'b0;
      val_we  = 1'b0;
      wr_addr = wr_addr_ff;
      wr_key  = rd_key_ff;
      wr_val  = rd_val_ff;
      if (cmd.shift_step && pend_ff) begin
         key_we = 1'b1;
         val_we = 1'b1;
      end else if (cmd.place) begin
         key_we  = 1'b1;
         val_we  = 1'b1;
         wr_addr = lo_addr;
         wr_key  = key_ff;
         wr_val  = value_ff;
      end else if (cmd.upd_value) begin
         val_we  = 1'b1;
         wr_addr = floor_addr;
         wr_val  = value_ff;
      end
   end

   // Memories: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   // Search window and count
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      count_in = count_ff;
      if (cmd.load_req) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (cmd.step_search) begin
         if (rd_key_ff <= key_ff) begin
            lo_in = CW'(mid_ff) + 1'b1;
         end else begin
            hi_in = CW'(mid_ff);
         end
      end
      if (cmd.inc_count) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.dec_count) begin
         count_in = count_dec;
      end
   end

   // Shift engine: read one entry, write it one slot over in the next cycle
   always_comb begin
      ptr_in     = ptr_ff;
      wr_addr_in = wr_addr_ff;
      rem_in     = rem_ff;
      pend_in    = pend_ff;
      up_in      = up_ff;
      if (cmd.shift_start) begin
         up_in   = (act_ff == ACT_INSERT);
         ptr_in  = (act_ff == ACT_INSERT) ? count_dec[AW-1:0] : lo_addr;
         rem_in  = count_ff - lo_ff;
         pend_in = 1'b0;
      end else if (cmd.shift_step) begin
         if (rem_ff != '0) begin
            pend_in    = 1'b1;
            wr_addr_in = up_ff ? (ptr_ff + 1'b1) : (ptr_ff - 1'b1);
            ptr_in     = up_ff ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);
            rem_in     = rem_ff - 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
   end

   // Result capture
   always_comb begin
      res_status_in = STAT_OK;
      res_pos_in    = '0;
      res_exact_in  = 1'b0;
      res_key_in    = '0;
      res_val_in    = '0;
      case (cmd.res_kind)
         RES_FULL: begin
            res_status_in = STAT_FULL;
         end
         RES_FLOOR: begin
            res_pos_in   = floor_addr;
            res_exact_in = key_eq;
            res_key_in   = rd_key_ff;
            res_val_in   = rd_val_ff;
         end
         RES_HIT: begin
            res_pos_in   = floor_addr;
            res_exact_in = key_eq;
         end
         RES_PLACED: begin
            res_pos_in = lo_addr;
         end
         default: begin
            res_status_in = STAT_NOT_FOUND;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         rem_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         rem_ff   <= rem_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      ptr_ff     <= ptr_in;
      wr_addr_ff <= wr_addr_in;
      up_ff      <= up_in;
      if (cmd.rd_mid) begin
         mid_ff <= mid_full[AW-1:0];
      end
      if (cmd.load_req) begin
         act_ff   <= req_action;
         key_ff   <= KEY_BITS'(req_search_key);
         value_ff <= VALUE_BITS'(req_entry_value);
      end
      if (cmd.res_we) begin
         res_status_ff <= res_status_in;
         res_pos_ff    <= res_pos_in;
         res_exact_ff  <= res_exact_in;
         res_key_ff    <= res_key_in;
         res_val_ff    <= res_val_in;
      end
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_pos_ff    <= POS_W'(res_pos_ff);
         out_exact_ff  <= res_exact_ff;
         out_key_ff    <= KEY_W'(res_key_ff);
         out_val_ff    <= VALUE_W'(res_val_ff);
         out_total_ff  <= TOTAL_W'(count_ff);
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_exact_match = out_exact_ff;
   assign rsp_found_key   = out_key_ff;
   assign rsp_found_value = out_val_ff;
   assign rsp_entry_total = out_total_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/snt_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module snt_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire snt_pkg::stat_type stat,
   output snt_pkg::cmd_type       cmd
);
   import snt_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PROBE  = 7'b0000010,
      S_CMP    = 7'b0000100,
      S_CHECK  = 7'b0001000,
      S_SHIFT  = 7'b0010000,
      S_PLACE  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stat.span_open) begin
               cmd.rd_mid = 1'b1;
               state_in   = S_CMP;
            end else if (!stat.lo_zero) begin
               cmd.rd_floor = 1'b1;
               state_in     = S_CHECK;
            end else if (stat.action == ACT_INSERT) begin
               // new smallest key
               if (stat.table_full) begin
                  cmd.res_we   = 1'b1;
                  cmd.res_kind = RES_FULL;
                  state_in     = S_FINISH;
               end else if (stat.shift_none) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end
            end else begin
               cmd.res_we   = 1'b1;
               cmd.res_kind = RES_NOT_FOUND;
               state_in     = S_FINISH;
            end
         end
         S_CMP: begin
            cmd.step_search = 1'b1;
            state_in        = S_PROBE;
         end
         S_CHECK: begin
            // floor entry is on the read port
            if (stat.action == ACT_INSERT) begin
               if (stat.key_eq) begin
                  cmd.upd_value = 1'b1;
                  cmd.res_we    = 1'b1;
                  cmd.res_kind  = RES_HIT;
                  state_in      = S_FINISH;
               end else if (stat.table_full) begin
                  cmd.res_we   = 1'b1;
                  cmd.res_kind = RES_FULL;
                  state_in     = S_FINISH;
               end else if (stat.shift_none) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end
            end else if (stat.action == ACT_REMOVE) begin
               cmd.res_we    = 1'b1;
               cmd.res_kind  = RES_HIT;
               cmd.dec_count = 1'b1;
               if (stat.shift_none) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end
            end else begin
               cmd.res_we   = 1'b1;
               cmd.res_kind = RES_FLOOR;
               state_in     = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = (stat.action == ACT_INSERT) ? S_PLACE : S_FINISH;
            end
         end
         S_PLACE: begin
            cmd.place     = 1'b1;
            cmd.inc_count = 1'b1;
            cmd.res_we    = 1'b1;
            cmd.res_kind  = RES_PLACED;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output item valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import snt_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int IDLE_LIMIT   = 3000;
   localparam int TAIL_CYCLES  = 100;
   localparam int RANDOM_ITEMS = 850;

   // Action code 3 has no name in the package; the table serves it as a find
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [KEY_W-1:0]    KEY_TOP    = {KEY_W{1'b1}};
   localparam logic [VALUE_W-1:0]  VALUE_TOP  = {VALUE_W{1'b1}};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic                exact_match;
      logic [KEY_W-1:0]    found_key;
      logic [VALUE_W-1:0]  found_value;
      logic [TOTAL_W-1:0]  entry_total;
   } node_result_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   snt_req_if req_ch ();
   snt_rsp_if rsp_ch ();

   sorted_node_table_unit #(.CAPACITY(CAPACITY)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow copy of the node table
   logic [KEY_W-1:0]   table_keys   [CAPACITY];
   logic [VALUE_W-1:0] table_values [CAPACITY];
   int                 table_fill = 0;
   int                 peak_fill = 0;

   node_result_type pending_results[$];
   node_result_type head_result;

   int fail_count = 0;
   int results_checked = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int find_count = 0, insert_count = 0, remove_count = 0, unused_count = 0;
   int full_count = 0, miss_count = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_phase = 0;

   // Apply one request to the shadow table and return the answer it must give
   function automatic node_result_type apply_request(input logic [ACTION_W-1:0] act,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VALUE_W-1:0] value);
      node_result_type r;
      int              floor_pos;
      int              slot;
      int              i;
      r = '0;
      r.status = STAT_OK;
      // keys are strictly ascending: floor is the last key not above the request
      floor_pos = -1;
      for (i = 0; i < table_fill; i++)
         if (table_keys[i] <= key) floor_pos = i;

      case (act)
         ACT_INSERT: begin
            if (floor_pos >= 0 && table_keys[floor_pos] == key) begin
               table_values[floor_pos] = value;
               r.position = floor_pos[POS_W-1:0];
               r.exact_match = 1'b1;
            end else if (table_fill >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               slot = floor_pos + 1;
               for (i = table_fill; i > slot; i--) begin
                  table_keys[i] = table_keys[i-1];
                  table_values[i] = table_values[i-1];
               end
               table_keys[slot] = key;
               table_values[slot] = value;
               table_fill++;
               r.position = slot[POS_W-1:0];
            end
         end
         ACT_REMOVE: begin
            if (floor_pos < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               r.exact_match = (table_keys[floor_pos] == key);
               for (i = floor_pos; i + 1 < table_fill; i++) begin
                  table_keys[i] = table_keys[i+1];
                  table_values[i] = table_values[i+1];
               end
               table_fill--;
               r.position = floor_pos[POS_W-1:0];
            end
         end
         default: begin
            if (floor_pos < 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               r.position = floor_pos[POS_W-1:0];
               r.exact_match = (table_keys[floor_pos] == key);
               r.found_key = table_keys[floor_pos];
               r.found_value = table_values[floor_pos];
            end
         end
      endcase
      r.entry_total = table_fill[TOTAL_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, expected, actual);
         fail_count++;
      end
   endfunction

   function automatic logic [VALUE_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Keys cluster around stored entries and both ends of the key range
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      k = random_word();
      case ($urandom_range(0, 9))
         0, 1, 2: if (table_fill > 0) k = table_keys[$urandom_range(0, table_fill - 1)];
         3:       if (table_fill > 0)
                     k = table_keys[$urandom_range(0, table_fill - 1)]
                         + KEY_W'($urandom_range(0, 2)) - KEY_W'(1);
         4, 5:    k = KEY_W'($urandom_range(0, 400));
         6:       k = KEY_TOP - KEY_W'($urandom_range(0, 400));
         default: ;
      endcase
      return k;
   endfunction

   // Send one item in bursts with random gaps, predict its answer on acceptance
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value);
      int              gap;
      node_result_type r;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.search_key  <= key;
      req_ch.entry_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;

      r = apply_request(act, key, value);
      pending_results.push_back(r);
      if (table_fill > peak_fill) peak_fill = table_fill;
      case (act)
         ACT_FIND:   find_count++;
         ACT_INSERT: insert_count++;
         ACT_REMOVE: remove_count++;
         default:    unused_count++;
      endcase
      if (r.status == STAT_FULL) full_count++;
      if (r.status == STAT_NOT_FOUND) miss_count++;
   endtask

   // Hold off the sender until every answer is back
   task automatic wait_for_drain();
      burst_left = 0;
      if (pending_results.size() != 0) begin
         req_ch.valid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
      end
   endtask

   // Extremes of the key range, all actions, misses below the smallest key
   task automatic test_directed();
      send_request(ACT_FIND,   '0, '0);
      send_request(ACT_REMOVE, KEY_TOP, '0);
      send_request(ACT_UNUSED, 64'd5, '0);
      send_request(ACT_INSERT, 64'd1000, 64'hA5A5_5A5A_0F0F_F0F0);
      send_request(ACT_INSERT, '0, VALUE_TOP);
      send_request(ACT_INSERT, KEY_TOP, '0);
      send_request(ACT_INSERT, 64'd500, 64'h5555_5555_5555_5555);
      send_request(ACT_FIND,   KEY_TOP, random_word());
      send_request(ACT_FIND,   64'd750, '0);
      send_request(ACT_FIND,   '0, '0);
      send_request(ACT_INSERT, 64'd1000, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(ACT_UNUSED, 64'd1001, '0);
      send_request(ACT_REMOVE, 64'd499, '0);
      send_request(ACT_FIND,   '0, '0);
      send_request(ACT_REMOVE, 64'd100, '0);
      send_request(ACT_FIND,   KEY_TOP - 64'd1, '0);
      send_request(ACT_REMOVE, KEY_TOP, '0);
      send_request(ACT_INSERT, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF);
      send_request(ACT_FIND,   64'h7FFF_FFFF_FFFF_FFFF, '0);
      send_request(ACT_REMOVE, 64'd1000, '0);
      send_request(ACT_REMOVE, 64'd500, '0);
      send_request(ACT_REMOVE, KEY_TOP, '0);
      send_request(ACT_FIND,   KEY_TOP, '0);
      wait_for_drain();
   endtask

   // Fill every slot, then hit the full table with new keys, updates and finds, then remove one and insert
   task automatic test_full_table();
      int n;
      while (table_fill < CAPACITY)
         send_request(ACT_INSERT, pick_key(), random_word());
      for (n = 0; n < 34; n++) begin
         case ($urandom_range(0, 3))
            0:       send_request(ACT_INSERT, random_word(), random_word());
            1:       send_request(ACT_INSERT, table_keys[$urandom_range(0, CAPACITY - 1)],
                                  random_word());
            2:       send_request(ACT_FIND, pick_key(), random_word());
            default: send_request(ACT_UNUSED, pick_key(), random_word());
         endcase
      end
      send_request(ACT_REMOVE, pick_key(), random_word());
      send_request(ACT_INSERT, random_word(), random_word());
      wait_for_drain();
   endtask

   // Mixed traffic; the fill level wanders between near empty and near full
   task automatic test_random_traffic();
      int                  n;
      int                  roll;
      int                  fill_target;
      logic [ACTION_W-1:0] act;
      fill_target = 32;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       fill_target = 4;
               1:       fill_target = 32;
               default: fill_target = 62;
            endcase
         end
         if (n % 200 == 199 || $urandom_range(0, 99) == 0) wait_for_drain();
         roll = $urandom_range(0, 99);
         if (roll >= 96)
            act = ACT_UNUSED;
         else if (table_fill < fill_target)
            act = (roll < 55) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE : ACT_FIND;
         else
            act = (roll < 25) ? ACT_INSERT : (roll < 60) ? ACT_REMOVE : ACT_FIND;
         send_request(act, pick_key(), random_word());
      end
      wait_for_drain();
   endtask

   // Remove until empty, then probe the empty table
   task automatic test_drain_table();
      int n;
      while (table_fill > 0) begin
         if ($urandom_range(0, 4) == 0)
            send_request(ACT_FIND, pick_key(), random_word());
         else
            send_request(ACT_REMOVE, pick_key(), random_word());
      end
      for (n = 0; n < 6; n++)
         send_request(($urandom_range(0, 1) == 0) ? ACT_FIND : ACT_REMOVE, pick_key(),
                      random_word());
      wait_for_drain();
   endtask

   // Result checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no request outstanding");
            fail_count++;
         end else begin
            head_result = pending_results.pop_front();
            check_field("status",      64'(head_result.status),      64'(rsp_ch.status));
            check_field("position",    64'(head_result.position),    64'(rsp_ch.position));
            check_field("exact_match", 64'(head_result.exact_match), 64'(rsp_ch.exact_match));
            check_field("found_key",   64'(head_result.found_key),   64'(rsp_ch.found_key));
            check_field("found_value", 64'(head_result.found_value), 64'(rsp_ch.found_value));
            check_field("entry_total", 64'(head_result.entry_total), 64'(rsp_ch.entry_total));
         end
         results_checked++;
      end

      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 150);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            STALL_NONE:     rsp_ch.ready <= 1'b1;
            STALL_LIGHT:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_ch.ready <= ((stall_phase % 7) < 4);
            default:        rsp_ch.ready <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_FIND;
      req_ch.search_key  = '0;
      req_ch.entry_value = '0;
      rsp_ch.ready       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_table();
      test_random_traffic();
      test_drain_table();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests: %0d finds, %0d inserts, %0d removes, %0d unused-code",
               find_count + insert_count + remove_count + unused_count, find_count,
               insert_count, remove_count, unused_count);
      $display("Checked %0d results: %0d table-full, %0d not-found, peak fill %0d of %0d",
               results_checked, full_count, miss_count, peak_fill, CAPACITY);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
